>>> rtl/mcmp_pkg.sv
// Shared types and constants for the MIDI channel message parser.
package mcmp_pkg;

  // Command codes on the result channel
  typedef enum logic [2:0] {
    CMD_NOTE_OFF = 3'd0,
    CMD_NOTE_ON  = 3'd1,
    CMD_KEY_VOL  = 3'd2,
    CMD_XPOSE    = 3'd3,
    CMD_CUR_VOL  = 3'd4
  } cmd_t;

  // Status nibbles (upper four bits of a voice status byte)
  localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
  localparam logic [3:0] ST_NOTE_ON   = 4'h9;
  localparam logic [3:0] ST_AFTER     = 4'hA;
  localparam logic [3:0] ST_CTRL      = 4'hB;
  localparam logic [3:0] ST_PROGRAM   = 4'hC;
  localparam logic [3:0] ST_PRESSURE  = 4'hD;
  localparam logic [3:0] ST_PITCH     = 4'hE;
  localparam logic [3:0] ST_SYSTEM    = 4'hF;

  // Channel number that a configuration write may not select
  localparam logic [3:0] CHAN_LOCKED  = 4'd9;

  // Program number that selects a transpose of two
  localparam logic [6:0] PROG_XPOSE   = 7'h47;
  localparam logic [6:0] XPOSE_AMOUNT = 7'd2;

  // Total message length in bytes for a status nibble, zero if not a voice message
  function automatic logic [1:0] msg_length(input logic [3:0] hi);
    logic [1:0] len;
    begin
      case (hi) inside
        ST_NOTE_OFF, ST_NOTE_ON, ST_AFTER, ST_CTRL, ST_PITCH: len = 2'd3;
        ST_PROGRAM, ST_PRESSURE:                               len = 2'd2;
        default:                                               len = 2'd0;
      endcase
      return len;
    end
  endfunction

endpackage

>>> rtl/midi_channel_message_parser.sv
// MIDI channel message parser: byte input register, message state, command output register.
//
// Takes one received MIDI byte per beat and assembles channel voice messages for the
// channel held in rx_channel (zero-based; a write of 9 is dropped). Note off, note on,
// aftertouch, program change and channel pressure each produce one command beat when
// their last data byte arrives; control change and pitch wheel complete silently.
// There is no running status, and bytes 0xF0 and above are ignored without disturbing
// a pending message. Each byte is held in the input register and its command, if any,
// is loaded into the output register as the byte leaves, so a byte can be accepted
// every cycle unless stalled; the output register frees the input side whenever it is
// empty or its beat is being taken. Write rx_channel only while no bytes are in flight.
module midi_channel_message_parser (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_write,
  input  logic [3:0] rx_channel,
  // byte input
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  // command output
  output logic       cmd_valid,
  input  logic       cmd_stall,
  output logic [2:0] cmd,
  output logic [6:0] key,
  output logic [6:0] value
);

  logic [3:0] channel;
  logic       in_valid;
  logic [7:0] in_byte;
  logic [3:0] pending_status, pending_status_next;
  logic [6:0] first_data, first_data_next;
  logic [1:0] expected_len, expected_len_next;
  logic [1:0] byte_count, byte_count_next;
  logic       proc;
  logic       emit;
  logic [2:0] cmd_next;
  logic [6:0] key_next, value_next;
  logic [6:0] fd;
  logic [1:0] len;
  logic [1:0] count_inc;

  // Advance the input register when the output register can take a result
  assign proc     = in_valid && (!cmd_valid || !cmd_stall);
  assign rx_stall = in_valid && !proc;

  // Hold the receive channel, drop writes of the locked channel
  always_ff @(posedge clk) begin
    if (rst) begin
      channel <= 4'd0;
    end else if (cfg_write && rx_channel != mcmp_pkg::CHAN_LOCKED) begin
      channel <= rx_channel;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!rx_stall) begin
      in_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rx_stall && rx_valid) begin
      in_byte <= rx_byte;
    end
  end

  // Decode one byte against the message state
  always_comb begin
    pending_status_next = pending_status;
    first_data_next     = first_data;
    expected_len_next   = expected_len;
    byte_count_next     = byte_count;
    emit                = 1'b0;
    cmd_next            = mcmp_pkg::CMD_NOTE_OFF;
    key_next            = 7'd0;
    value_next          = 7'd0;
    len                 = 2'd0;
    count_inc           = byte_count + 2'd1;
    fd                  = (byte_count == 2'd1) ? in_byte[6:0] : first_data;

    if (in_byte[7]) begin
      // status byte: system bytes leave the state alone
      if (in_byte[7:4] != mcmp_pkg::ST_SYSTEM) begin
        len = (in_byte[3:0] == channel) ? mcmp_pkg::msg_length(in_byte[7:4]) : 2'd0;
        expected_len_next = len;
        byte_count_next   = (len != 2'd0) ? 2'd1 : 2'd0;
        if (len != 2'd0) begin
          pending_status_next = in_byte[7:4];
        end
      end
    end else if (byte_count < expected_len) begin
      // data byte of a pending message
      if (byte_count == 2'd1) begin
        first_data_next = in_byte[6:0];
      end
      byte_count_next = count_inc;
      if (count_inc == expected_len) begin
        expected_len_next = 2'd0;
        case (pending_status)
          mcmp_pkg::ST_NOTE_OFF: begin
            emit     = 1'b1;
            cmd_next = mcmp_pkg::CMD_NOTE_OFF;
            key_next = fd;
          end
          mcmp_pkg::ST_NOTE_ON: begin
            emit       = 1'b1;
            cmd_next   = mcmp_pkg::CMD_NOTE_ON;
            key_next   = fd;
            value_next = in_byte[6:0];
          end
          mcmp_pkg::ST_AFTER: begin
            emit       = 1'b1;
            cmd_next   = mcmp_pkg::CMD_KEY_VOL;
            key_next   = fd;
            value_next = in_byte[6:0];
          end
          mcmp_pkg::ST_PROGRAM: begin
            emit       = 1'b1;
            cmd_next   = mcmp_pkg::CMD_XPOSE;
            value_next = (fd == mcmp_pkg::PROG_XPOSE) ? mcmp_pkg::XPOSE_AMOUNT : 7'd0;
          end
          mcmp_pkg::ST_PRESSURE: begin
            emit       = 1'b1;
            cmd_next   = mcmp_pkg::CMD_CUR_VOL;
            value_next = fd;
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
    end
  end

  // Message state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_status <= 4'd0;
      first_data     <= 7'd0;
      expected_len   <= 2'd0;
      byte_count     <= 2'd0;
    end else if (proc) begin
      pending_status <= pending_status_next;
      first_data     <= first_data_next;
      expected_len   <= expected_len_next;
      byte_count     <= byte_count_next;
    end
  end

  // Output register: load on a result, drop the beat once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (proc) begin
      cmd_valid <= emit;
    end else if (!cmd_stall) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      cmd   <= cmd_next;
      key   <= key_next;
      value <= value_next;
    end
  end

  // A new result only follows a byte leaving the input register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(cmd_valid) |-> $past(in_valid))
    else $error("result appeared without a byte in the input register");

  // Byte count stays below the length of a pending message
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    expected_len != 2'd0 |-> byte_count < expected_len)
    else $error("byte count reached message length while pending");

  // Commands without a note carry key zero
  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && (cmd == mcmp_pkg::CMD_XPOSE || cmd == mcmp_pkg::CMD_CUR_VOL) |-> key == 7'd0)
    else $error("nonzero key on transpose or volume command");

  // Note off carries value zero
  a_note_off_value: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd == mcmp_pkg::CMD_NOTE_OFF |-> value == 7'd0)
    else $error("nonzero value on note off");

  // Command code stays within the defined set
  a_cmd_range: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> cmd <= mcmp_pkg::CMD_CUR_VOL)
    else $error("undefined command code");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the MIDI channel message parser: byte stimulus, command checks.
module testbench;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // Track parser state per accepted byte and hold the commands it should emit
  class midi_cmd_predictor;
    typedef struct {
      mcmp_pkg::cmd_t cmd;
      logic [6:0]     key;
      logic [6:0]     value;
    } midi_cmd_t;

    midi_cmd_t  expected_cmds[$];
    logic [3:0] channel;
    logic [3:0] msg_hi;
    logic [6:0] first_byte;
    int         msg_len;
    int         bytes_in;
    int         errors;
    int         bytes_taken;
    int         cmds_seen;

    function new();
      channel     = '0;
      msg_hi      = '0;
      first_byte  = '0;
      msg_len     = 0;
      bytes_in    = 0;
      errors      = 0;
      bytes_taken = 0;
      cmds_seen   = 0;
    endfunction

    // Drop a write that selects the locked channel
    function void set_channel(input logic [3:0] ch);
      if (ch != mcmp_pkg::CHAN_LOCKED) begin
        channel = ch;
      end
    endfunction

    function int voice_len(input logic [3:0] hi);
      case (hi) inside
        mcmp_pkg::ST_NOTE_OFF, mcmp_pkg::ST_NOTE_ON, mcmp_pkg::ST_AFTER,
        mcmp_pkg::ST_CTRL, mcmp_pkg::ST_PITCH: return 3;
        mcmp_pkg::ST_PROGRAM, mcmp_pkg::ST_PRESSURE: return 2;
        default: return 0;
      endcase
    endfunction

    function void accept_byte(input logic [7:0] b);
      midi_cmd_t c;
      bytes_taken++;
      // System and realtime bytes leave a pending message alone
      if (b[7:4] == mcmp_pkg::ST_SYSTEM) begin
        return;
      end
      // Status: start a message on our channel, cancel on anything else
      if (b[7]) begin
        msg_len  = (b[3:0] == channel) ? voice_len(b[7:4]) : 0;
        bytes_in = (msg_len != 0) ? 1 : 0;
        if (msg_len != 0) begin
          msg_hi = b[7:4];
        end
        return;
      end
      // Data: ignore unless a message is still open
      if (bytes_in >= msg_len) begin
        return;
      end
      if (bytes_in == 1) begin
        first_byte = b[6:0];
      end
      bytes_in++;
      if (bytes_in != msg_len) begin
        return;
      end
      msg_len = 0;
      c.key   = first_byte;
      c.value = b[6:0];
      case (msg_hi)
        mcmp_pkg::ST_NOTE_OFF: begin
          c.cmd   = mcmp_pkg::CMD_NOTE_OFF;
          c.value = '0;
        end
        mcmp_pkg::ST_NOTE_ON: c.cmd = mcmp_pkg::CMD_NOTE_ON;
        mcmp_pkg::ST_AFTER:   c.cmd = mcmp_pkg::CMD_KEY_VOL;
        mcmp_pkg::ST_PROGRAM: begin
          c.cmd   = mcmp_pkg::CMD_XPOSE;
          c.key   = '0;
          c.value = (first_byte == mcmp_pkg::PROG_XPOSE) ? mcmp_pkg::XPOSE_AMOUNT : '0;
        end
        mcmp_pkg::ST_PRESSURE: begin
          c.cmd   = mcmp_pkg::CMD_CUR_VOL;
          c.key   = '0;
          c.value = first_byte;
        end
        default: return;
      endcase
      expected_cmds.push_back(c);
    endfunction

    function void check_cmd(input logic [2:0] c, input logic [6:0] k, input logic [6:0] v);
      midi_cmd_t e;
      cmds_seen++;
      if (expected_cmds.size() == 0) begin
        errors++;
        $error("unexpected command beat: cmd %0d key %0d value %0d", c, k, v);
        return;
      end
      e = expected_cmds.pop_front();
      if (c !== e.cmd) begin
        errors++;
        $error("cmd mismatch: expected %0d, actual %0d", e.cmd, c);
      end
      if (k !== e.key) begin
        errors++;
        $error("key mismatch: expected %0d, actual %0d", e.key, k);
      end
      if (v !== e.value) begin
        errors++;
        $error("value mismatch: expected %0d, actual %0d", e.value, v);
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_write = 1'b0;
  logic [3:0] cfg_chan  = '0;
  logic       rx_valid  = 1'b0;
  logic [7:0] rx_byte   = '0;
  logic       rx_stall;
  logic       cmd_valid;
  logic       cmd_stall = 1'b0;
  logic [2:0] cmd;
  logic [6:0] key;
  logic [6:0] value;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;

  midi_cmd_predictor pred;

  midi_channel_message_parser u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .rx_channel (cfg_chan),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .key        (key),
    .value      (value)
  );

  always #4 clk = ~clk;

  // Check each taken command beat, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && cmd_valid && !cmd_stall) begin
      pred.check_cmd(cmd, key, value);
    end
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      cmd_stall <= 1'b1;
    end else begin
      cmd_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Offer one byte after a random gap and hold it until the beat is taken
  task automatic send_byte(input logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall) begin
      @(posedge clk);
    end
    pred.accept_byte(b);
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) begin
      send_byte(seq[i]);
    end
  endtask

  // Mostly complete messages on our channel; the rest cut short, foreign or stray bytes
  task automatic send_message();
    int         pick;
    int         len;
    logic [3:0] hi;
    logic [3:0] ch;
    logic [7:0] d;
    pick = $urandom_range(0, 99);
    if (pick >= 90) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    hi = 4'(mcmp_pkg::ST_NOTE_OFF +
            $urandom_range(0, mcmp_pkg::ST_PITCH - mcmp_pkg::ST_NOTE_OFF));
    ch = pred.channel;
    if (pick >= 75) begin
      ch = 4'(ch + $urandom_range(1, 15));
    end
    len = (hi == mcmp_pkg::ST_PROGRAM || hi == mcmp_pkg::ST_PRESSURE) ? 2 : 3;
    if (pick >= 65 && pick < 75) begin
      len = $urandom_range(1, len - 1);
    end
    send_byte({hi, ch});
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte({mcmp_pkg::ST_SYSTEM, 4'($urandom_range(0, 15))});
      end
      d = 8'($urandom_range(0, 127));
      if (hi == mcmp_pkg::ST_PROGRAM && $urandom_range(0, 3) == 0) begin
        d = {1'b0, mcmp_pkg::PROG_XPOSE};
      end
      send_byte(d);
    end
  endtask

  task automatic run_phase(input idle_mode_t mode, input int n_bytes);
    int stop;
    case (mode)
      IDLE_SEND: begin
        send_idle_pct  = 87;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct  = 0;
        recv_stall_pct = 87;
      end
      IDLE_BOTH: begin
        send_idle_pct  = 30;
        recv_stall_pct = 30;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
    stop = pred.bytes_taken + n_bytes;
    while (pred.bytes_taken < stop) begin
      send_message();
    end
  endtask

  // Drain the parser, let the last byte clear the pipeline, then write the channel
  task automatic write_channel(input logic [3:0] ch);
    rx_valid <= 1'b0;
    @(posedge clk);
    while (pred.expected_cmds.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_chan  <= ch;
    @(posedge clk);
    cfg_write <= 1'b0;
    pred.set_channel(ch);
  endtask

  initial begin
    pred = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every message type on the reset channel, realtime mid-message, cancel, stray data
    send_seq('{8'h90, 8'h3C, 8'h64, 8'h80, 8'h7F, 8'h00, 8'hA0, 8'h00, 8'h7F,
               8'hC0, 8'h47, 8'hD0, 8'h7F, 8'hB0, 8'h07, 8'h10, 8'hE0, 8'h00,
               8'h40, 8'h90, 8'hF8, 8'h40, 8'h00, 8'h90, 8'h95, 8'h20});

    // Top channel, then a dropped write of the locked channel
    write_channel(4'd15);
    send_seq('{8'h9F, 8'h7F, 8'h7F});
    write_channel(mcmp_pkg::CHAN_LOCKED);
    send_seq('{8'h99, 8'h10, 8'hFF, 8'hDF, 8'h00});

    run_phase(IDLE_NONE, 380);
    write_channel(4'd0);
    run_phase(IDLE_SEND, 380);
    write_channel(4'($urandom_range(0, 15)));
    run_phase(IDLE_RECV, 380);
    write_channel(mcmp_pkg::CHAN_LOCKED);
    run_phase(IDLE_BOTH, 380);
    write_channel(4'($urandom_range(0, 15)));

    // Long receiver hold-off while bytes keep coming, so the input backs up
    hold_request = 400;
    run_phase(IDLE_NONE, 380);

    rx_valid <= 1'b0;
    @(posedge clk);
    while (pred.expected_cmds.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    $display("Covered %0d bytes and %0d command beats across channels 0, 15 and random,",
             pred.bytes_taken, pred.cmds_seen);
    $display("with dropped channel-9 writes, sender/receiver idling and a long output hold.");
    if (pred.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/mcmp_pkg.sv
rtl/midi_channel_message_parser.sv
tb/testbench.sv
